### hdl/fac_pkg.sv
package fac_pkg;

   // Store geometry and field widths
   localparam int SAMPLE_DEPTH = 65536;
   localparam int COUNT_BITS   = 16;
   localparam int ADDR_BITS    = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
   localparam int SUM_BITS     = 24;
   localparam int INDEX_BITS   = 16;
   localparam int VALUE_BITS   = 8;
   localparam int AVG_BITS     = 8;
   localparam int FRAMES_BITS  = 16;
   localparam int DIV_CNT_BITS = $clog2(SUM_BITS);

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // Item kinds carried on the request tuser
   typedef enum logic [1:0] {
      FUNC_ADD   = 2'd0,
      FUNC_READ  = 2'd1,
      FUNC_CLEAR = 2'd2
   } func_type;

   // Result status carried on the response tuser
   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NO_FRAMES = 2'd1,
      STATUS_SATURATED = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ADD_WR,
      ST_RD_LOAD,
      ST_DIV,
      ST_FINISH
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic clear_step;
      logic add_start;
      logic read_start;
      logic entry_clear;
      logic add_write;
      logic div_load;
      logic div_step;
      logic rsp_load;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic clear_last;
      logic count_zero;
      logic div_last;
      logic rsp_busy;
   } stat_type;

endpackage

### hdl/fac_ram.sv
module fac_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic                                        rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/fac_datapath.sv
module fac_datapath import fac_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   output stat_type               stat,
   input  logic [INDEX_BITS-1:0]  req_index,
   input  logic [VALUE_BITS-1:0]  req_value,
   input  logic                   req_frame_end,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output logic [AVG_BITS-1:0]    rsp_average,
   output logic [FRAMES_BITS-1:0] rsp_frames,
   output status_type             rsp_status
);

   logic [ADDR_BITS-1:0]    clr_addr_ff, clr_addr_in;
   logic [COUNT_BITS-1:0]   count_ff, count_in;
   logic                    sat_ff, sat_in;
   logic [ADDR_BITS-1:0]    addr_ff;
   logic [VALUE_BITS-1:0]   value_ff;
   logic                    idx_ok_ff;
   logic [COUNT_BITS-1:0]   rem_ff, rem_in;
   logic [SUM_BITS-1:0]     quo_ff, quo_in;
   logic [DIV_CNT_BITS-1:0] div_cnt_ff, div_cnt_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [AVG_BITS-1:0]     avg_ff;
   logic [FRAMES_BITS-1:0]  frames_ff;
   status_type              status_ff;

   logic                    req_idx_ok;
   logic [ADDR_BITS-1:0]    req_addr;
   logic                    ram_wr_en;
   logic [ADDR_BITS-1:0]    ram_wr_addr;
   logic [SUM_BITS-1:0]     ram_wr_data;
   logic                    ram_rd_en;
   logic [SUM_BITS-1:0]     ram_rd_data;
   logic [SUM_BITS:0]       add_sum;
   logic                    add_ovf;
   logic [COUNT_BITS:0]     shifted;
   logic                    ge;
   logic [COUNT_BITS:0]     twice;
   logic [COUNT_BITS:0]     cnt_ext;
   logic                    round_up;
   logic                    avg_clamp;
   logic [AVG_BITS-1:0]     avg_res;
   logic [FRAMES_BITS-1:0]  frames_res;
   status_type              status_res;

   // Decode the request position
   assign req_idx_ok = 32'(req_index) < 32'(SAMPLE_DEPTH);
   assign req_addr   = ADDR_BITS'(req_index);

   // Add the held sample to the fetched sum, hold at full scale
   assign add_sum = {1'b0, ram_rd_data} + (SUM_BITS+1)'(value_ff);
   assign add_ovf = add_sum[SUM_BITS];

   // Steer the single write port: clearing pass, entry clear, add write-back
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = addr_ff;
      ram_wr_data = '0;
      if (cmd.clear_step) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_addr_ff;
      end else if (cmd.entry_clear) begin
         ram_wr_en   = req_idx_ok;
         ram_wr_addr = req_addr;
      end else if (cmd.add_write) begin
         ram_wr_en   = idx_ok_ff;
         ram_wr_data = add_ovf ? '1 : add_sum[SUM_BITS-1:0];
      end
   end

   assign ram_rd_en = cmd.add_start | cmd.read_start;

   fac_ram #(
      .WIDTH (SUM_BITS),
      .DEPTH (SAMPLE_DEPTH)
   ) u_sums (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (req_addr),
      .rd_data (ram_rd_data)
   );

   // Advance the clearing pass address
   assign clr_addr_in = cmd.clear_step ? clr_addr_ff + 1'b1 : clr_addr_ff;

   // Update frame count and sticky saturation flag
   always_comb begin
      count_in = count_ff;
      sat_in   = sat_ff;
      if (cmd.add_start && req_frame_end) begin
         if (count_ff == COUNT_MAX) begin
            sat_in = 1'b1;
         end else begin
            count_in = count_ff + 1'b1;
         end
      end
      if (cmd.entry_clear && req_frame_end) begin
         count_in = '0;
         sat_in   = 1'b0;
      end
      if (cmd.add_write && idx_ok_ff && add_ovf) begin
         sat_in = 1'b1;
      end
   end

   // One restoring division step per cycle
   assign shifted = {rem_ff, quo_ff[SUM_BITS-1]};
   assign ge      = shifted >= {1'b0, count_ff};

   always_comb begin
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      div_cnt_in = div_cnt_ff;
      if (cmd.div_load) begin
         rem_in     = '0;
         quo_in     = idx_ok_ff ? ram_rd_data : '0;
         div_cnt_in = '0;
      end else if (cmd.div_step) begin
         rem_in     = ge ? COUNT_BITS'(shifted - {1'b0, count_ff})
                         : shifted[COUNT_BITS-1:0];
         quo_in     = {quo_ff[SUM_BITS-2:0], ge};
         div_cnt_in = div_cnt_ff + 1'b1;
      end
   end

   // Round half to even, then clamp to the byte range
   assign twice     = {rem_ff, 1'b0};
   assign cnt_ext   = {1'b0, count_ff};
   assign round_up  = (twice > cnt_ext) || ((twice == cnt_ext) && quo_ff[0]);
   assign avg_clamp = (|quo_ff[SUM_BITS-1:AVG_BITS])
                      || (round_up && (&quo_ff[AVG_BITS-1:0]));

   always_comb begin
      frames_res = (32'(count_ff) > 32'((1 << FRAMES_BITS) - 1))
                   ? '1 : FRAMES_BITS'(count_ff);
      if (count_ff == '0) begin
         avg_res    = '0;
         status_res = STATUS_NO_FRAMES;
      end else begin
         avg_res    = avg_clamp ? '1
                      : quo_ff[AVG_BITS-1:0] + AVG_BITS'(round_up);
         status_res = sat_ff ? STATUS_SATURATED : STATUS_OK;
      end
   end

   // Output register: load on finish, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff  <= '0;
         count_ff     <= '0;
         sat_ff       <= 1'b0;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_addr_ff  <= clr_addr_in;
         count_ff     <= count_in;
         sat_ff       <= sat_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.add_start || cmd.read_start) begin
         addr_ff   <= req_addr;
         value_ff  <= req_value;
         idx_ok_ff <= req_idx_ok;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (cmd.rsp_load) begin
         avg_ff    <= avg_res;
         frames_ff <= frames_res;
         status_ff <= status_res;
      end
   end

   assign stat.clear_last = clr_addr_ff == ADDR_BITS'(SAMPLE_DEPTH - 1);
   assign stat.count_zero = count_ff == '0;
   assign stat.div_last   = div_cnt_ff == DIV_CNT_BITS'(SUM_BITS - 1);
   assign stat.rsp_busy   = rsp_valid_ff && !rsp_ready;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_average = avg_ff;
   assign rsp_frames  = frames_ff;
   assign rsp_status  = status_ff;

endmodule

### hdl/fac_ctrl.sv
module fac_ctrl import fac_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] req_func,
   input  stat_type   stat,
   output logic       req_ready,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   func_type  func;
   logic      accept;

   assign func   = func_type'(req_func);
   assign accept = req_valid && (state_ff == ST_IDLE);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (stat.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               case (func)
                  FUNC_ADD:  state_in = ST_ADD_WR;
                  FUNC_READ: state_in = ST_RD_LOAD;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_ADD_WR:  state_in = ST_IDLE;
         ST_RD_LOAD: state_in = stat.count_zero ? ST_FINISH : ST_DIV;
         ST_DIV: begin
            if (stat.div_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!stat.rsp_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // Commands
   always_comb begin
      cmd            = '0;
      req_ready      = state_ff == ST_IDLE;
      cmd.clear_step = state_ff == ST_CLEAR;
      cmd.add_write  = state_ff == ST_ADD_WR;
      cmd.div_load   = state_ff == ST_RD_LOAD;
      cmd.div_step   = state_ff == ST_DIV;
      cmd.rsp_load   = (state_ff == ST_FINISH) && !stat.rsp_busy;
      if (accept) begin
         case (func)
            FUNC_ADD:   cmd.add_start   = 1'b1;
            FUNC_READ:  cmd.read_start  = 1'b1;
            FUNC_CLEAR: cmd.entry_clear = 1'b1;
            default:    cmd.add_start   = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### hdl/frame_average_accumulator_core.sv
// Frame averaging accumulator. Add items sum a byte sample into a 24-bit
// per-position accumulator (one RAM entry per position) and, with tlast set,
// count a frame; read items return the sum divided by the frame count,
// rounded half to even and clamped to 0..255, with the count and a status;
// clear items zero one entry, and with tlast also the count and the sticky
// saturation flag. One item is in work at a time. An add does a RAM read,
// then a write-back, a clear a single write, and a read a RAM read, the
// divider load, 24 radix-2 steps of the restoring divider, and the rounding
// into the output register, skipping the divider with no frames counted.
// After reset the block runs a clearing pass over all 65536 entries, one
// accumulator entry a cycle, with req_tready low. The response register lets
// the next item enter while a result waits to be taken.
module frame_average_accumulator_core import fac_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // sample_index[15:0], sample_value[23:16]
   input  logic [1:0]  req_tuser,  // func[1:0]
   input  logic        req_tlast,  // frame_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // average_value[7:0], frames_counted[23:8]
   output logic [1:0]  rsp_tuser   // status[1:0]
);

   cmd_type                cmd;
   stat_type               stat;
   logic [AVG_BITS-1:0]    rsp_average;
   logic [FRAMES_BITS-1:0] rsp_frames;
   status_type             rsp_status;

   fac_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_func  (req_tuser),
      .stat      (stat),
      .req_ready (req_tready),
      .cmd       (cmd)
   );

   fac_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_index     (req_tdata[INDEX_BITS-1:0]),
      .req_value     (req_tdata[INDEX_BITS+VALUE_BITS-1:INDEX_BITS]),
      .req_frame_end (req_tlast),
      .rsp_ready     (rsp_tready),
      .rsp_valid     (rsp_tvalid),
      .rsp_average   (rsp_average),
      .rsp_frames    (rsp_frames),
      .rsp_status    (rsp_status)
   );

   // Pack the result item
   assign rsp_tdata = {rsp_frames, rsp_average};
   assign rsp_tuser = rsp_status;

   // The clearing pass runs once, right after reset
   a_clear_once: assert property (@(posedge clock) disable iff (reset)
      !cmd.clear_step |=> !cmd.clear_step)
      else $error("clearing pass restarted");

   // No item enters while the divider is stepping
   a_div_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> !req_tready)
      else $error("item accepted during division");

   // A zero frame count always reports no frames with a zero average
   a_no_frames: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[23:8] == 16'd0) |->
         (rsp_tuser == STATUS_NO_FRAMES) && (rsp_tdata[7:0] == 8'd0))
      else $error("zero count without no-frames status");

   // The no-frames status only comes with a zero count
   a_status_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == STATUS_NO_FRAMES) |-> rsp_tdata[23:8] == 16'd0)
      else $error("no-frames status with nonzero count");

endmodule
